// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the LED matrix scanner checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hdl/lmps_pkg.sv -----
// ----------------------------------------------------------------------------
// lmps_pkg
// Types and fixed field widths for the LED matrix PWM scanner.
// ----------------------------------------------------------------------------
package lmps_pkg;

	localparam int CMD_W     = 3;
	localparam int LED_IDX_W = 4;
	localparam int LEVEL_W   = 6;
	localparam int ROWSEL_W  = 9;
	localparam int COLS_W    = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 3'd0,
		CMD_READ  = 3'd1,
		CMD_CLEAR = 3'd2,
		CMD_LATCH = 3'd3,
		CMD_TICK  = 3'd4,
		CMD_BLANK = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_LATCH
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [LED_IDX_W-1:0] led_row;
		logic [LED_IDX_W-1:0] led_col;
		logic [LEVEL_W-1:0]   level;
	} in_t;

	typedef struct packed {
		logic [ROWSEL_W-1:0] row_select;
		logic [COLS_W-1:0]   column_bits;
		logic [LEVEL_W-1:0]  read_level;
		logic                cycle_end;
		logic                blanked;
	} out_t;

endpackage

// ----- hdl/led_matrix_pwm_scanner_core.sv -----
// ----------------------------------------------------------------------------
// led_matrix_pwm_scanner_core
// Multiplexed LED matrix driver with per-LED PWM brightness.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result shows on
// result for exactly one cycle with done high and cannot be held off. Write,
// read and scan tick read one row word of a memory, then do the update or
// compare; clear and blank finish straight from idle; latch copies the
// working store into the display store one row per cycle through the working
// memory's read port. busy is low again in the cycle done shows, so the next
// command may start then. Levels are kept as one word per matrix row in two
// memories (working and display).
module led_matrix_pwm_scanner_core #(
	parameter int LEVEL_BITS  = 6,
	parameter int PWM_STEPS   = 64,
	parameter int MATRIX_SIZE = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lmps_pkg::in_t item,
	output logic          busy,
	output lmps_pkg::out_t result,
	output logic          done
);

	import lmps_pkg::*;

	localparam int ROW_W  = $clog2(MATRIX_SIZE);
	localparam int CNT_W  = $clog2(MATRIX_SIZE + 1);
	localparam int STEP_W = $clog2(PWM_STEPS);
	localparam int WORD_W = MATRIX_SIZE * LEVEL_BITS;
	localparam int CMP_W  = (LEVEL_BITS > STEP_W) ? LEVEL_BITS : STEP_W;

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [ROW_W-1:0]       scan_row_q, scan_row_d;
	logic [STEP_W-1:0]      scan_step_q, scan_step_d;

	cmd_t                   cmd_s1;
	logic [ROW_W-1:0]       row_s1;
	logic [LED_IDX_W-1:0]   col_s1;
	logic [LEVEL_BITS-1:0]  lvl_s1;
	logic                   in_range_s1;

	out_t                   result_q, res_d;
	logic                   done_q, done_d;

	logic                   accept, capture, in_range;
	logic [ROW_W-1:0]       acc_row, lat_row;

	logic                   wk_clear, wk_we, dp_we;
	logic [ROW_W-1:0]       wk_raddr;
	logic [WORD_W-1:0]      wk_rdata, dp_rdata, merged;
	logic [LEVEL_BITS-1:0]  rd_field;
	logic [MATRIX_SIZE-1:0] col_vec, row_vec;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign in_range = ({1'b0, item.led_row} < (LED_IDX_W + 1)'(MATRIX_SIZE))
		&& ({1'b0, item.led_col} < (LED_IDX_W + 1)'(MATRIX_SIZE));
	assign acc_row = in_range ? item.led_row[ROW_W-1:0] : '0;
	assign lat_row = ROW_W'(cnt_q - CNT_W'(1));

	lmps_rowmem #(.DEPTH(MATRIX_SIZE), .WIDTH(WORD_W)) u_working (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (wk_clear),
		.we    (wk_we),
		.waddr (row_s1),
		.wdata (merged),
		.raddr (wk_raddr),
		.rdata (wk_rdata)
	);

	lmps_rowmem #(.DEPTH(MATRIX_SIZE), .WIDTH(WORD_W)) u_display (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (1'b0),
		.we    (dp_we),
		.waddr (lat_row),
		.wdata (wk_rdata),
		.raddr (scan_row_q),
		.rdata (dp_rdata)
	);

	always_comb begin
		merged   = wk_rdata;
		rd_field = '0;
		for (int c = 0; c < MATRIX_SIZE; c++) begin
			if (col_s1 == LED_IDX_W'(c)) begin
				merged[c*LEVEL_BITS +: LEVEL_BITS] = lvl_s1;
				rd_field = wk_rdata[c*LEVEL_BITS +: LEVEL_BITS];
			end
			col_vec[c] = CMP_W'(dp_rdata[c*LEVEL_BITS +: LEVEL_BITS]) > CMP_W'(scan_step_q);
		end
		row_vec = MATRIX_SIZE'(1) << scan_row_q;
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		scan_row_d  = scan_row_q;
		scan_step_d = scan_step_q;
		done_d      = 1'b0;
		res_d       = '0;
		capture     = 1'b0;
		wk_clear    = 1'b0;
		wk_we       = 1'b0;
		wk_raddr    = acc_row;
		dp_we       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					capture = 1'b1;
					unique case (item.command) inside
						CMD_WRITE, CMD_READ, CMD_TICK: begin
							state_d = ST_ACCESS;
						end
						CMD_CLEAR: begin
							wk_clear = 1'b1;
							done_d   = 1'b1;
						end
						CMD_LATCH: begin
							wk_raddr = '0;
							cnt_d    = CNT_W'(1);
							state_d  = ST_LATCH;
						end
						CMD_BLANK: begin
							res_d.blanked = 1'b1;
							done_d        = 1'b1;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_ACCESS: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
				case (cmd_s1)
					CMD_WRITE: begin
						wk_we = in_range_s1;
					end
					CMD_READ: begin
						res_d.read_level = in_range_s1 ? LEVEL_W'(rd_field) : '0;
					end
					CMD_TICK: begin
						res_d.row_select  = ROWSEL_W'(row_vec);
						res_d.column_bits = COLS_W'(col_vec);
						if (scan_row_q == ROW_W'(MATRIX_SIZE - 1)) begin
							scan_row_d = '0;
							if (scan_step_q == STEP_W'(PWM_STEPS - 1)) begin
								scan_step_d     = '0;
								res_d.cycle_end = 1'b1;
							end else begin
								scan_step_d = scan_step_q + STEP_W'(1);
							end
						end else begin
							scan_row_d = scan_row_q + ROW_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
			ST_LATCH: begin
				dp_we = 1'b1;
				if (cnt_q == CNT_W'(MATRIX_SIZE)) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					wk_raddr = cnt_q[ROW_W-1:0];
					cnt_d    = cnt_q + CNT_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			scan_row_q  <= '0;
			scan_step_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			scan_row_q  <= scan_row_d;
			scan_step_q <= scan_step_d;
			done_q      <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
		if (capture) begin
			cmd_s1      <= cmd_t'(item.command);
			row_s1      <= item.led_row[ROW_W-1:0];
			col_s1      <= item.led_col;
			lvl_s1      <= LEVEL_BITS'(item.level);
			in_range_s1 <= in_range;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

// ----- hdl/lmps_rowmem.sv -----
// ----------------------------------------------------------------------------
// lmps_rowmem
// Row-word store, registered read, per-row valid bits so that
// rows never written (or cleared) read as zero.
// ----------------------------------------------------------------------------
module lmps_rowmem #(
	parameter int DEPTH = 9,
	parameter int WIDTH = 54
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_s1;
	logic             rd_valid_s1;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rd_s1       <= mem_q[raddr];
		rd_valid_s1 <= valid_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	assign rdata = rd_valid_s1 ? rd_s1 : '0;

endmodule

// ----- hdl/lmps_checker.sv -----
// ----------------------------------------------------------------------------
// lmps_checker
// Port-level checks for the LED matrix scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmps_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input lmps_pkg::in_t  item,
	input logic           busy,
	input lmps_pkg::out_t result,
	input logic           done
);

	import lmps_pkg::*;

	// an accepted command either finishes next cycle or keeps the block busy
	`ASSERT_NEXT(a_accept_progress, clk, arst_n, start && !busy, busy || done)
	// the result beat always leaves the block free for the next command
	`ASSERT_IMPLY(a_done_not_busy, clk, arst_n, done, !busy)
	// row drive is never more than one row
	`ASSERT_IMPLY(a_row_onehot, clk, arst_n, done, $onehot0(result.row_select))
	// blank beat shows everything dark
	`ASSERT_IMPLY(a_blank_dark, clk, arst_n, done && result.blanked,
		(result.row_select == '0) && (result.column_bits == '0) && !result.cycle_end)

endmodule

bind led_matrix_pwm_scanner_core lmps_checker u_lmps_checker (.*);

// ----- bench/tb_led_matrix_pwm_scanner_core.sv -----
// ----------------------------------------------------------------------------
// tb_led_matrix_pwm_scanner_core
// Self-checking bench for the LED matrix PWM scanner: a short directed table,
// then random edit bursts, latches, clears and long scan runs. Each result
// beat is checked per field against its typed table value or a local model.
// ----------------------------------------------------------------------------
module tb_led_matrix_pwm_scanner_core;
	timeunit 1ns;
	timeprecision 1ps;

	import lmps_pkg::*;

	localparam int MSIZE      = 9;
	localparam int STEPS      = 64;
	localparam int RAND_BEATS = 850;

	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

	localparam out_t ALL_OFF    = '0;
	localparam out_t BLANK_OUT  = '{9'd0, 9'd0, 6'd0, 1'b0, 1'b1};
	localparam out_t FIRST_TICK = '{9'd1, 9'd0, 6'd0, 1'b0, 1'b0};

	typedef struct {
		in_t  beat;
		bit   typed;
		out_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	in_t  item;
	logic busy;
	out_t result;
	logic done;

	logic [LEVEL_W-1:0] work_lvl [MSIZE][MSIZE];
	logic [LEVEL_W-1:0] disp_lvl [MSIZE][MSIZE];
	int unsigned scan_row_q;
	int unsigned scan_step_q;

	out_t pending_results [$];
	int   mismatches;
	int   n_sent;
	int   burst_left;

	dir_row_t directed_rows [22] = '{
		'{'{CMD_READ,  4'd0,  4'd0,  6'd0},  1'b1, ALL_OFF},
		'{'{CMD_TICK,  4'd0,  4'd0,  6'd0},  1'b1, FIRST_TICK},
		'{'{CMD_WRITE, 4'd0,  4'd0,  6'd63}, 1'b0, ALL_OFF},
		'{'{CMD_WRITE, 4'd8,  4'd8,  6'd42}, 1'b0, ALL_OFF},
		'{'{CMD_WRITE, 4'd8,  4'd0,  6'd21}, 1'b0, ALL_OFF},
		'{'{CMD_WRITE, 4'd0,  4'd8,  6'd1},  1'b0, ALL_OFF},
		'{'{CMD_WRITE, 4'd9,  4'd0,  6'd5},  1'b1, ALL_OFF},
		'{'{CMD_WRITE, 4'd3,  4'd15, 6'd7},  1'b1, ALL_OFF},
		'{'{CMD_READ,  4'd0,  4'd0,  6'd0},  1'b0, ALL_OFF},
		'{'{CMD_READ,  4'd8,  4'd8,  6'd63}, 1'b0, ALL_OFF},
		'{'{CMD_READ,  4'd15, 4'd15, 6'd0},  1'b1, ALL_OFF},
		'{'{CMD_READ,  4'd2,  4'd9,  6'd0},  1'b1, ALL_OFF},
		'{'{CMD_LATCH, 4'd0,  4'd0,  6'd0},  1'b1, ALL_OFF},
		'{'{CMD_TICK,  4'd15, 4'd15, 6'd63}, 1'b0, ALL_OFF},
		'{'{CMD_BLANK, 4'd0,  4'd0,  6'd0},  1'b1, BLANK_OUT},
		'{'{CMD_SPARE6, 4'd15, 4'd15, 6'd63}, 1'b1, ALL_OFF},
		'{'{CMD_SPARE7, 4'd0,  4'd0,  6'd0},  1'b1, ALL_OFF},
		'{'{CMD_TICK,  4'd0,  4'd0,  6'd0},  1'b0, ALL_OFF},
		'{'{CMD_CLEAR, 4'd0,  4'd0,  6'd0},  1'b1, ALL_OFF},
		'{'{CMD_READ,  4'd0,  4'd0,  6'd0},  1'b1, ALL_OFF},
		'{'{CMD_READ,  4'd8,  4'd8,  6'd0},  1'b1, ALL_OFF},
		'{'{CMD_WRITE, 4'd8,  4'd8,  6'd63}, 1'b0, ALL_OFF}
	};

	led_matrix_pwm_scanner_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.result (result),
		.done   (done)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic out_t scan_model(input in_t b);
		out_t        o;
		bit          hit;
		int unsigned r;
		int          k;
		o   = '0;
		hit = (b.led_row < MSIZE) && (b.led_col < MSIZE);
		case (b.command)
			CMD_WRITE: if (hit) work_lvl[b.led_row][b.led_col] = b.level;
			CMD_READ:  if (hit) o.read_level = work_lvl[b.led_row][b.led_col];
			CMD_CLEAR: begin
				for (r = 0; r < MSIZE; r++)
					for (k = 0; k < MSIZE; k++)
						work_lvl[r][k] = '0;
			end
			CMD_LATCH: disp_lvl = work_lvl;
			CMD_TICK: begin
				r = (scan_row_q >= MSIZE) ? 0 : scan_row_q;
				o.row_select = 9'd1 << r;
				for (k = 0; k < MSIZE; k++)
					if (disp_lvl[r][k] > scan_step_q)
						o.column_bits[k] = 1'b1;
				if (r == MSIZE - 1) begin
					if (scan_step_q >= STEPS - 1) begin
						o.cycle_end = 1'b1;
						scan_step_q = 0;
					end else begin
						scan_step_q++;
					end
					scan_row_q = 0;
				end else begin
					scan_row_q = r + 1;
				end
			end
			CMD_BLANK: o.blanked = 1'b1;
			default: ;
		endcase
		return o;
	endfunction

	function automatic in_t mk(input logic [CMD_W-1:0] cmd, input int unsigned r,
			input int unsigned c, input int unsigned lvl);
		in_t b;
		b.command = cmd;
		b.led_row = LED_IDX_W'(r);
		b.led_col = LED_IDX_W'(c);
		b.level   = LEVEL_W'(lvl);
		return b;
	endfunction

	function automatic int unsigned rand_level();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 63;
			2: return 62;
			default: return $urandom_range(0, 63);
		endcase
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// one command beat; bursts of back-to-back beats separated by random gaps
	task automatic send_beat(input in_t b, input bit typed = 1'b0, input out_t want = '0);
		out_t pred;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 16);
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		burst_left--;
		start <= 1'b1;
		item  <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = scan_model(b);
		pending_results.push_back(typed ? want : pred);
		n_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	always @(posedge clk) begin
		out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with none expected, actual %h", $time, result);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("row_select", want.row_select, result.row_select);
				check_field("column_bits", want.column_bits, result.column_bits);
				check_field("read_level", want.read_level, result.read_level);
				check_field("cycle_end", want.cycle_end, result.cycle_end);
				check_field("blanked", want.blanked, result.blanked);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_led_matrix_pwm_scanner_core: FAIL");
		$finish;
	end

	initial begin
		int n;
		int kind;
		int r;
		int c;
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		mismatches  = 0;
		n_sent      = 0;
		burst_left  = 0;
		scan_row_q  = 0;
		scan_step_q = 0;
		for (r = 0; r < MSIZE; r++)
			for (c = 0; c < MSIZE; c++) begin
				work_lvl[r][c] = '0;
				disp_lvl[r][c] = '0;
			end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
		drain();

		n_sent = 0;
		while (n_sent < RAND_BEATS) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				// scan run, occasionally blanked
				n = $urandom_range(8, 120);
				repeat (n) begin
					if ($urandom_range(0, 31) == 0)
						send_beat(mk(CMD_BLANK, $urandom_range(0, 15), $urandom_range(0, 15),
							$urandom_range(0, 63)));
					else
						send_beat(mk(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 15),
							$urandom_range(0, 63)));
				end
			end else if (kind < 75) begin
				// edit burst, usually followed by a latch
				n = $urandom_range(1, 12);
				repeat (n) begin
					case ($urandom_range(0, 19))
						0, 1: send_beat(mk(($urandom_range(0, 1) ? CMD_WRITE : CMD_READ),
							$urandom_range(9, 15), $urandom_range(0, 15), rand_level()));
						2, 3: send_beat(mk(($urandom_range(0, 1) ? CMD_WRITE : CMD_READ),
							$urandom_range(0, 8), $urandom_range(9, 15), rand_level()));
						4: send_beat(mk(($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7),
							$urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 63)));
						5, 6, 7, 8, 9: send_beat(mk(CMD_READ, $urandom_range(0, 8),
							$urandom_range(0, 8), $urandom_range(0, 63)));
						default: send_beat(mk(CMD_WRITE, $urandom_range(0, 8),
							$urandom_range(0, 8), rand_level()));
					endcase
				end
				if ($urandom_range(0, 9) == 0)
					drain();
				if ($urandom_range(0, 4) != 0)
					send_beat(mk(CMD_LATCH, $urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 63)));
			end else if (kind < 80) begin
				send_beat(mk(CMD_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 63)));
			end else begin
				send_beat(mk(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 15),
					$urandom_range(0, 15), $urandom_range(0, 63)));
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_led_matrix_pwm_scanner_core: PASS");
		else
			$display("tb_led_matrix_pwm_scanner_core: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/lmps_pkg.sv
hdl/lmps_rowmem.sv
hdl/led_matrix_pwm_scanner_core.sv
hdl/lmps_checker.sv
bench/tb_led_matrix_pwm_scanner_core.sv
